// ===== src/crro_pkg.sv =====
// Package for the circle and rotated rectangle overlap pipeline.
// Holds the CORDIC constants, the arctangent table and the types shared by the cells.
// No dependencies.
package crro_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int IDX_W         = 5;
  localparam int CORDIC_W      = 32;
  localparam int DIFF_W        = 17;
  localparam int PROD_W        = DIFF_W + CORDIC_W;
  localparam int SUM_W         = PROD_W + 1;
  localparam int FRAC_SHIFT    = 30;
  localparam int ROT_W         = SUM_W - FRAC_SHIFT;
  localparam int EXT_W         = 15;
  localparam int R2_W          = EXT_W + 1;
  localparam int THR_W         = EXT_W + 2;
  localparam int SQ_W          = 2 * THR_W;

  localparam logic signed [CORDIC_W-1:0] INV_GAIN_Q30 = 32'sd652032874;
  localparam logic signed [CORDIC_W-1:0] ONE_Q30      = 32'sd1073741824;
  localparam logic signed [SUM_W-1:0]    ROUND_HALF   = 50'sd536870912;

  localparam logic signed [CORDIC_W-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef struct packed {
    logic                       valid;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
    logic signed [DIFF_W-1:0]   dx;
    logic signed [DIFF_W-1:0]   dy;
    quad_t                      quad;
    logic                       zero;
    logic [EXT_W-1:0]           rad;
    logic [EXT_W-1:0]           w;
    logic [EXT_W-1:0]           h;
  } cell_t;

endpackage

// ===== src/crro_cordic_cell.sv =====
// One CORDIC rotation cell of the overlap pipeline.
// Depends on crro_pkg for the cell record and the arctangent table.
module crro_cordic_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [crro_pkg::IDX_W-1:0]  idx,
  input  crro_pkg::cell_t             cell_in,
  output crro_pkg::cell_t             cell_out
);

  logic signed [crro_pkg::CORDIC_W-1:0] xs;
  logic signed [crro_pkg::CORDIC_W-1:0] ys;
  logic signed [crro_pkg::CORDIC_W-1:0] atan_val;
  crro_pkg::cell_t                      cell_next;

  assign xs       = cell_in.x >>> idx;
  assign ys       = cell_in.y >>> idx;
  assign atan_val = crro_pkg::ATAN_TABLE[idx];

  always_comb begin
    cell_next = cell_in;
    if (!cell_in.z[crro_pkg::CORDIC_W-1]) begin
      cell_next.x = cell_in.x - ys;
      cell_next.y = cell_in.y + xs;
      cell_next.z = cell_in.z - atan_val;
    end else begin
      cell_next.x = cell_in.x + ys;
      cell_next.y = cell_in.y - xs;
      cell_next.z = cell_in.z + atan_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (en) begin
      cell_out <= cell_next;
    end
  end

endmodule

// ===== src/crro_overlap_back.sv =====
// Back end of the overlap pipeline: quadrant fix, rotation, rounding, compares.
// Ends in the output register. Depends on crro_pkg.
module crro_overlap_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  crro_pkg::cell_t cell_in,
  output logic            res_valid,
  output logic            res_overlap
);

  localparam int CW = crro_pkg::CORDIC_W;
  localparam int DW = crro_pkg::DIFF_W;
  localparam int PW = crro_pkg::PROD_W;
  localparam int SW = crro_pkg::SUM_W;
  localparam int RW = crro_pkg::ROT_W;
  localparam int EW = crro_pkg::EXT_W;
  localparam int TW = crro_pkg::THR_W;
  localparam int QW = crro_pkg::SQ_W;
  localparam int R2W = crro_pkg::R2_W;

  logic signed [CW-1:0] cr, sr, c_next, s_next;

  logic                 v1;
  logic signed [CW-1:0] c1, s1;
  logic signed [DW-1:0] dx1, dy1;
  logic [EW-1:0]        rad1, w1, h1;

  logic                 v2;
  logic signed [PW-1:0] pxc, pys, pyc, pxs;
  logic [EW-1:0]        rad2, w2, h2;

  logic signed [SW-1:0] vx, vy;
  logic                 v3;
  logic signed [RW-1:0] xr, yr;
  logic [EW-1:0]        rad3, w3, h3;

  logic [RW-1:0]        ax, ay, ax2, ay2, ex_full, ey_full;
  logic [R2W-1:0]       r2;
  logic [TW-1:0]        thr_x, thr_y;
  logic                 reject, accept;

  logic                 v4;
  logic                 known4, hit4;
  logic [TW-1:0]        ex4, ey4;
  logic [R2W-1:0]       r24;

  logic                 v5;
  logic                 known5, hit5;
  logic [QW-1:0]        ex2, ey2;
  logic [2*R2W-1:0]     rr;
  logic [QW:0]          sq_sum;

  assign cr = cell_in.zero ? crro_pkg::ONE_Q30 : cell_in.x;
  assign sr = cell_in.zero ? '0 : cell_in.y;

  always_comb begin
    unique case (cell_in.quad)
      crro_pkg::QUAD_0: begin
        c_next = cr;
        s_next = sr;
      end
      crro_pkg::QUAD_1: begin
        c_next = -sr;
        s_next = cr;
      end
      crro_pkg::QUAD_2: begin
        c_next = -cr;
        s_next = -sr;
      end
      crro_pkg::QUAD_3: begin
        c_next = sr;
        s_next = -cr;
      end
      default: begin
        c_next = cr;
        s_next = sr;
      end
    endcase
  end

  assign vx = SW'(pxc) + SW'(pys) + crro_pkg::ROUND_HALF;
  assign vy = SW'(pyc) - SW'(pxs) + crro_pkg::ROUND_HALF;

  assign ax      = xr[RW-1] ? RW'(-xr) : RW'(xr);
  assign ay      = yr[RW-1] ? RW'(-yr) : RW'(yr);
  assign ax2     = {ax[RW-2:0], 1'b0};
  assign ay2     = {ay[RW-2:0], 1'b0};
  assign r2      = {rad3, 1'b0};
  assign thr_x   = TW'(w3) + TW'(r2);
  assign thr_y   = TW'(h3) + TW'(r2);
  assign reject  = (ax2 > RW'(thr_x)) || (ay2 > RW'(thr_y));
  assign accept  = (ax2 <= RW'(w3)) || (ay2 <= RW'(h3));
  assign ex_full = ax2 - RW'(w3);
  assign ey_full = ay2 - RW'(h3);

  assign sq_sum = (QW + 1)'(ex2) + (QW + 1)'(ey2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      v1        <= cell_in.valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      res_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1   <= c_next;
      s1   <= s_next;
      dx1  <= cell_in.dx;
      dy1  <= cell_in.dy;
      rad1 <= cell_in.rad;
      w1   <= cell_in.w;
      h1   <= cell_in.h;

      pxc  <= PW'(dx1) * PW'(c1);
      pys  <= PW'(dy1) * PW'(s1);
      pyc  <= PW'(dy1) * PW'(c1);
      pxs  <= PW'(dx1) * PW'(s1);
      rad2 <= rad1;
      w2   <= w1;
      h2   <= h1;

      xr   <= vx[SW-1:crro_pkg::FRAC_SHIFT];
      yr   <= vy[SW-1:crro_pkg::FRAC_SHIFT];
      rad3 <= rad2;
      w3   <= w2;
      h3   <= h2;

      known4 <= reject || accept;
      hit4   <= !reject;
      ex4    <= ex_full[TW-1:0];
      ey4    <= ey_full[TW-1:0];
      r24    <= r2;

      known5 <= known4;
      hit5   <= hit4;
      ex2    <= QW'(ex4) * QW'(ex4);
      ey2    <= QW'(ey4) * QW'(ey4);
      rr     <= (2 * R2W)'(r24) * (2 * R2W)'(r24);

      res_overlap <= known5 ? hit5 : (sq_sum <= (QW + 1)'(rr));
    end
  end

endmodule

// ===== src/circle_rotated_rect_overlap.sv =====
// Circle against rotated rectangle overlap test, fully pipelined.
// Throughput is one transaction per cycle while the output is taken, set by one
// CORDIC cell per rotation step.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears all valid bits; the data registers are not reset.
// Depends on crro_pkg, crro_cordic_cell and crro_overlap_back.
module circle_rotated_rect_overlap (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] circle_x,
  input  logic [15:0] circle_y,
  input  logic [14:0] circle_radius,
  input  logic [15:0] rect_x,
  input  logic [15:0] rect_y,
  input  logic [14:0] rect_width,
  input  logic [14:0] rect_height,
  input  logic [15:0] rect_angle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        overlap
);

  localparam int N = crro_pkg::CORDIC_STAGES;
  localparam int CW = crro_pkg::CORDIC_W;
  localparam int DW = crro_pkg::DIFF_W;

  logic                 en;
  logic [15:0]          ang_shift;
  logic [13:0]          resid;
  logic signed [14:0]   resid_s;
  crro_pkg::cell_t      front_next;
  crro_pkg::cell_t      chain [N+1];
  logic signed [CW-1:0] z_last;
  logic [CW-1:0]        z_abs;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign ang_shift = rect_angle + 16'd8192;
  assign resid     = ang_shift[13:0];
  assign resid_s   = signed'({1'b0, resid}) - 15'sd8192;

  always_comb begin
    front_next.valid = in_valid;
    front_next.x     = crro_pkg::INV_GAIN_Q30;
    front_next.y     = '0;
    front_next.z     = {resid_s[14], resid_s, 16'b0};
    front_next.dx    = DW'(signed'(circle_x)) - DW'(signed'(rect_x));
    front_next.dy    = DW'(signed'(circle_y)) - DW'(signed'(rect_y));
    front_next.quad  = crro_pkg::quad_t'(ang_shift[15:14]);
    front_next.zero  = (resid == 14'd8192);
    front_next.rad   = circle_radius;
    front_next.w     = rect_width;
    front_next.h     = rect_height;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (en) begin
      chain[0] <= front_next;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    crro_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .idx      (crro_pkg::IDX_W'(i)),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  crro_overlap_back u_back (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .cell_in     (chain[N]),
    .res_valid   (out_valid),
    .res_overlap (overlap)
  );

  assign z_last = chain[N].z;
  assign z_abs  = z_last[CW-1] ? CW'(-z_last) : CW'(z_last);

  // The residual angle left after the last cell is within twice the last arctangent step.
  a_cordic_converged: assert property (@(posedge clk) disable iff (rst)
    chain[N].valid |-> (z_abs <= CW'(2 * crro_pkg::ATAN_TABLE[N-1])))
    else $error("CORDIC residual angle out of range");

  // Residual angles stay within a half quadrant, so the cosine is positive.
  a_cosine_positive: assert property (@(posedge clk) disable iff (rst)
    chain[N].valid |-> !chain[N].x[CW-1])
    else $error("CORDIC cosine negative");

  // A waiting result holds the whole pipeline in place.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(chain[N]))
    else $error("pipeline moved during output stall");

endmodule
